@@ hdl/fpg_pkg.sv @@
// Package with constants and item types for the factoradic permutation generator.
package fpg_pkg;

    localparam int MaxElements = 16;
    localparam int ValueWidth  = 32;
    localparam int IdxW        = $clog2(MaxElements);
    localparam int CntW        = $clog2(MaxElements + 1);

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_NEXT  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SORT,
        ST_EMIT,
        ST_INCR
    } t_state;

    typedef struct packed {
        logic [1:0]         op;
        logic [3:0]         position;
        logic signed [31:0] element_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_value;
        logic [3:0]         out_position;
        logic               last_element;
        logic               wrapped;
    } t_out_item;

    // Controls broadcast to every cell of the chain.
    typedef struct packed {
        logic            load;
        logic [IdxW-1:0] load_pos;
        logic            sort_even;
        logic            sort_odd;
        logic            copy;
        logic            pick;
        logic [IdxW-1:0] pick_idx;
        logic [CntW-1:0] count;
    } t_cell_ctl;

endpackage

@@ hdl/fpg_cell.sv @@
// One cell of the chain: holds a loaded value and a working-list value.
module fpg_cell
    import fpg_pkg::*;
(
    input  logic                         i_clk,
    input  logic [IdxW-1:0]              i_index,
    input  t_cell_ctl                    i_ctl,
    input  logic signed [ValueWidth-1:0] i_load_value,
    input  logic signed [ValueWidth-1:0] i_prev_loaded,
    input  logic signed [ValueWidth-1:0] i_next_loaded,
    input  logic signed [ValueWidth-1:0] i_next_work,
    output logic signed [ValueWidth-1:0] o_loaded,
    output logic signed [ValueWidth-1:0] o_work
);

    logic signed [ValueWidth-1:0] r_loaded, n_loaded;
    logic signed [ValueWidth-1:0] r_work, n_work;
    logic [CntW-1:0]              w_idx_ext;
    logic                         w_even, w_low_of_pair, w_high_of_pair;

    assign w_idx_ext = CntW'(i_index);
    assign w_even    = ~i_index[0];
    // Pair membership for the current compare-exchange phase.
    assign w_low_of_pair  = (i_ctl.sort_even & w_even) | (i_ctl.sort_odd & ~w_even);
    assign w_high_of_pair = (i_ctl.sort_even & ~w_even) | (i_ctl.sort_odd & w_even);

    // Odd-even transposition sort step, load, list copy, and pick shift.
    always_comb begin
        n_loaded = r_loaded;
        n_work   = r_work;
        if (i_ctl.load && i_ctl.load_pos == i_index) begin
            n_loaded = i_load_value;
        end
        if (w_low_of_pair && (w_idx_ext + 1'b1) < i_ctl.count) begin
            if (r_loaded > i_next_loaded) begin
                n_loaded = i_next_loaded;
            end
        end
        if (w_high_of_pair && i_index != '0 && w_idx_ext < i_ctl.count) begin
            if (i_prev_loaded > r_loaded) begin
                n_loaded = i_prev_loaded;
            end
        end
        if (i_ctl.copy) begin
            n_work = r_loaded;
        end else if (i_ctl.pick && i_index >= i_ctl.pick_idx) begin
            n_work = i_next_work;
        end
    end

    always_ff @(posedge i_clk) begin
        r_loaded <= n_loaded;
        r_work   <= n_work;
    end

    assign o_loaded = r_loaded;
    assign o_work   = r_work;

endmodule

@@ hdl/fpg_digits.sv @@
// Factoradic digit counter with a sequential right-to-left ripple.
module fpg_digits
    import fpg_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_clear,
    input  logic            i_step,
    input  logic [IdxW-1:0] i_pos,
    input  logic [CntW-1:0] i_count,
    input  logic [IdxW-1:0] i_rd_pos,
    output logic [3:0]      o_rd_digit,
    output logic            o_carry
);

    logic [3:0] r_digit [MaxElements];
    logic [3:0] w_inc;
    logic [CntW-1:0] w_radix;

    assign w_inc   = r_digit[i_pos] + 4'd1;
    assign w_radix = i_count - CntW'(i_pos);
    // Carry means this digit wrapped to zero.
    assign o_carry = (w_inc == 4'd0) || (CntW'(w_inc) >= w_radix);
    assign o_rd_digit = r_digit[i_rd_pos];

    // Digit update: one digit per step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            for (int k = 0; k < MaxElements; k++) begin
                r_digit[k] <= 4'd0;
            end
        end else if (i_step) begin
            r_digit[i_pos] <= o_carry ? 4'd0 : w_inc;
        end
    end

endmodule

@@ hdl/factoradic_permutation_generator.sv @@
// Top level: permutation enumerator built on a chain of value cells.
// Load and unused items leave the block idle; a start item runs the odd-even sort.
// A next item copies the list, then emits one value per cycle while the output is not
// stalled, then ripples the digits through the single shared digit update.
// Reset (synchronous, active low) clears the digits, sets the count to 1, and
// leaves stored values undefined.
module factoradic_permutation_generator
    import fpg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_item,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_item
);

    t_state          r_state, n_state;
    logic [4:0]      r_count_reg;
    logic [CntW-1:0] w_n;
    logic [CntW-1:0] r_step, n_step;
    logic [IdxW-1:0] r_dpos, n_dpos;
    logic            r_out_valid, n_out_valid;
    t_out_item       r_out, n_out;
    logic            w_accept, w_out_free;
    logic            w_carry, w_dig_step, w_dig_clear;
    logic [3:0]      w_digit;
    logic [IdxW-1:0] w_pick;
    logic [CntW-1:0] w_size;
    t_cell_ctl       w_ctl;
    logic signed [ValueWidth-1:0] w_loaded [MaxElements];
    logic signed [ValueWidth-1:0] w_work   [MaxElements];

    // Active count clamped into 1..MaxElements.
    always_comb begin
        if (r_count_reg == 5'd0) begin
            w_n = CntW'(1);
        end else if (CntW'(r_count_reg) > CntW'(MaxElements)) begin
            w_n = CntW'(MaxElements);
        end else begin
            w_n = CntW'(r_count_reg);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_reg <= 5'd1;
        end else if (i_cfg_we) begin
            r_count_reg <= i_cfg_data;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Emit: r_step 0 copies the list, then step k emits place k-1.
    assign w_size = w_n - r_step + CntW'(1);
    always_comb begin
        w_pick = IdxW'(w_digit);
        if (CntW'(w_digit) > w_size - CntW'(1)) begin
            w_pick = IdxW'(w_size - CntW'(1));
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && i_in_item.op == OP_START) begin
                    n_state = ST_SORT;
                end else if (w_accept && i_in_item.op == OP_NEXT) begin
                    n_state = ST_EMIT;
                end
            end
            ST_SORT: begin
                if (r_step == w_n) begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (r_step == w_n && w_out_free) begin
                    n_state = ST_INCR;
                end
            end
            ST_INCR: begin
                if (!w_carry || r_dpos == '0) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control outputs and counters.
    always_comb begin
        n_step      = r_step;
        n_dpos      = r_dpos;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        w_dig_step  = 1'b0;
        w_dig_clear = 1'b0;
        w_ctl       = '0;
        w_ctl.count = w_n;
        w_ctl.load_pos = i_in_item.position;
        unique case (r_state)
            ST_IDLE: begin
                n_step = '0;
                w_ctl.load = w_accept && i_in_item.op == OP_LOAD;
                w_dig_clear = w_accept && i_in_item.op == OP_START;
            end
            ST_SORT: begin
                w_ctl.sort_even = ~r_step[0];
                w_ctl.sort_odd  = r_step[0];
                n_step = r_step + CntW'(1);
            end
            ST_EMIT: begin
                if (r_step == '0) begin
                    w_ctl.copy = 1'b1;
                    n_step = CntW'(1);
                end else if (w_out_free) begin
                    w_ctl.pick     = 1'b1;
                    w_ctl.pick_idx = w_pick;
                    n_out_valid    = 1'b1;
                    n_out.out_value    = w_work[w_pick];
                    n_out.out_position = 4'(r_step - CntW'(1));
                    n_out.last_element = (r_step == w_n);
                    n_out.wrapped      = 1'b0;
                    n_step = r_step + CntW'(1);
                    n_dpos = IdxW'(w_n - CntW'(1));
                end
            end
            ST_INCR: begin
                w_dig_step = 1'b1;
                n_dpos = r_dpos - IdxW'(1);
                // The last result is still held here until the ripple ends.
                if (w_carry && r_dpos == '0) begin
                    n_out.wrapped = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Output valid is held back until the ripple decides the wrapped flag.
    assign o_out_valid = r_out_valid && !(r_state == ST_INCR);
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_dpos      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_dpos      <= n_dpos;
            r_out_valid <= (r_state == ST_INCR) ? r_out_valid : n_out_valid;
        end
        r_out <= n_out;
    end

    fpg_digits u_digits (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (w_dig_clear),
        .i_step     (w_dig_step),
        .i_pos      (r_dpos),
        .i_count    (w_n),
        .i_rd_pos   (IdxW'(r_step - CntW'(1))),
        .o_rd_digit (w_digit),
        .o_carry    (w_carry)
    );

    // Chain of cells; each sees its neighbors.
    for (genvar g = 0; g < MaxElements; g++) begin : g_cell
        fpg_cell u_cell (
            .i_clk         (i_clk),
            .i_index       (IdxW'(g)),
            .i_ctl         (w_ctl),
            .i_load_value  (i_in_item.element_value),
            .i_prev_loaded (w_loaded[(g == 0) ? 0 : g - 1]),
            .i_next_loaded (w_loaded[(g == MaxElements - 1) ? g : g + 1]),
            .i_next_work   (w_work[(g == MaxElements - 1) ? g : g + 1]),
            .o_loaded      (w_loaded[g]),
            .o_work        (w_work[g])
        );
    end

endmodule
